### hdl/swmga_pkg.sv
// Shared types and constants for the scene window majority gate adapter.
// Holds label codes, register indexes, reset values and controller/datapath structs.
// No dependencies.
package swmga_pkg;

    localparam int MAX_WINDOW_DEF = 64;

    localparam int LBL_W      = 3;
    localparam int NUM_LABELS = 6;
    localparam int WLEN_W     = 7;
    localparam int THR_W      = 9;
    localparam int Q16_W      = 16;
    localparam int FILL_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LBL_W-1:0] LBL_SILENCE = 3'd0;
    localparam logic [LBL_W-1:0] LBL_NOISE   = 3'd1;
    localparam logic [LBL_W-1:0] LBL_MUSIC   = 3'd2;
    localparam logic [LBL_W-1:0] LBL_UNKNOWN = 3'd5;

    // 0.33 and 0.85 in Q0.16
    localparam logic [Q16_W-1:0] Q16_033 = 16'd21627;
    localparam logic [Q16_W-1:0] Q16_085 = 16'd55706;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_WINDOW_LEN   = 3'd1,
        REG_DOM_THRESH   = 3'd2,
        REG_NOISE_GAIN   = 3'd3,
        REG_FLAT_TIGHT   = 3'd4,
        REG_MUSIC_SKIP   = 3'd5,
        REG_SILENCE_SKIP = 3'd6
    } cfg_reg_t;

    localparam logic              RST_ENABLE       = 1'b1;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LEN   = 7'd8;
    localparam logic [THR_W-1:0]  RST_DOM_THRESH   = 9'd154;
    localparam logic [Q16_W-1:0]  RST_NOISE_GAIN   = 16'd8192;
    localparam logic [Q16_W-1:0]  RST_FLAT_TIGHT   = 16'd45875;
    localparam logic              RST_MUSIC_SKIP   = 1'b1;
    localparam logic              RST_SILENCE_SKIP = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic push;
        logic drop;
        logic best;
        logic qual;
        logic load_out;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic push_req;
        logic full;
        logic over_limit;
    } dp_sts_t;

endpackage

### hdl/swmga_dp.sv
// Datapath of the scene window majority gate adapter: config registers, label ring,
// per-label counters, majority search, gate threshold arithmetic and output register.
// Depends on swmga_pkg.
module swmga_dp #(
    parameter int MAX_WINDOW = swmga_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swmga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swmga_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                cmd,
    input  logic [swmga_pkg::LBL_W-1:0]         scene_label,
    input  logic [swmga_pkg::LBL_W-1:0]         query_scene,
    input  logic [swmga_pkg::Q16_W-1:0]         base_rms_min,
    input  logic [swmga_pkg::Q16_W-1:0]         base_rms_border,
    input  logic [swmga_pkg::Q16_W-1:0]         base_flat_max,
    input  logic [swmga_pkg::Q16_W-1:0]         base_flat_warn,
    input  swmga_pkg::ctl_cmd_t                 ctl,
    output swmga_pkg::dp_sts_t                  sts,
    output logic [swmga_pkg::LBL_W-1:0]         dominant,
    output logic [swmga_pkg::Q16_W-1:0]         out_rms_min,
    output logic [swmga_pkg::Q16_W-1:0]         out_rms_border,
    output logic [swmga_pkg::Q16_W-1:0]         out_flat_max,
    output logic [swmga_pkg::Q16_W-1:0]         out_flat_warn,
    output logic                                asr_bypass,
    output logic [swmga_pkg::FILL_W-1:0]        fill
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OCC_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (OCC_W > swmga_pkg::WLEN_W) ? OCC_W : swmga_pkg::WLEN_W;
    localparam int QW    = OCC_W + swmga_pkg::THR_W;
    localparam int L_W   = swmga_pkg::LBL_W;
    localparam int Q_W   = swmga_pkg::Q16_W;

    // configuration
    logic                             enable_reg;
    logic [swmga_pkg::WLEN_W-1:0]     wlen_reg;
    logic [swmga_pkg::THR_W-1:0]      thr_reg;
    logic [Q_W-1:0]                   gain_reg;
    logic [Q_W-1:0]                   tight_reg;
    logic                             music_skip_reg;
    logic                             silence_skip_reg;

    // window state
    logic [L_W-1:0]                   ring [MAX_WINDOW];
    logic [L_W-1:0]                   rd_lbl_reg;
    logic [PTR_W-1:0]                 oldest_reg;
    logic [PTR_W-1:0]                 wr_ptr_reg;
    logic [OCC_W-1:0]                 occ_reg;
    logic [OCC_W-1:0]                 cnt_reg [swmga_pkg::NUM_LABELS];

    // latched item
    logic                             push_req_reg;
    logic [L_W-1:0]                   lbl_reg;
    logic [L_W-1:0]                   query_reg;
    logic [Q_W-1:0]                   rms_min_reg;
    logic [Q_W-1:0]                   rms_border_reg;
    logic [Q_W-1:0]                   flat_max_reg;
    logic [Q_W-1:0]                   flat_warn_reg;

    // evaluation pipeline
    logic [L_W-1:0]                   best_lbl_reg;
    logic [OCC_W-1:0]                 best_n_reg;
    logic [2*Q_W-1:0]                 rms_prod_reg;
    logic [2*Q_W-1:0]                 warn_prod_reg;
    logic [L_W-1:0]                   dom_reg;
    logic [Q_W-1:0]                   rms_sat_reg;

    // output register
    logic [L_W-1:0]                   dominant_reg;
    logic [Q_W-1:0]                   out_rms_min_reg;
    logic [Q_W-1:0]                   out_rms_border_reg;
    logic [Q_W-1:0]                   out_flat_max_reg;
    logic [Q_W-1:0]                   out_flat_warn_reg;
    logic                             skip_reg;
    logic [swmga_pkg::FILL_W-1:0]     fill_reg;

    logic [L_W-1:0]                   lbl_clean;
    logic [CMP_W-1:0]                 limit;
    logic [CMP_W-1:0]                 wlen_ext;
    logic [CMP_W-1:0]                 max_ext;
    logic [L_W-1:0]                   srch_lbl;
    logic [OCC_W-1:0]                 srch_n;
    logic [QW-1:0]                    qual_lhs;
    logic [QW-1:0]                    qual_rhs;
    logic [2*Q_W-1:0]                 border_prod;
    logic                             adapt;
    logic                             tighten;

    // map the unused codes 6 and 7 to unknown
    assign lbl_clean = (scene_label >= L_W'(swmga_pkg::NUM_LABELS))
                       ? swmga_pkg::LBL_UNKNOWN : scene_label;

    assign wlen_ext = CMP_W'(wlen_reg);
    assign max_ext  = CMP_W'(MAX_WINDOW);
    assign limit    = (wlen_ext > max_ext) ? max_ext : wlen_ext;

    assign sts.push_req   = push_req_reg;
    assign sts.full       = (occ_reg == OCC_W'(MAX_WINDOW));
    assign sts.over_limit = (CMP_W'(occ_reg) > limit);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_WINDOW - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= swmga_pkg::RST_ENABLE;
            wlen_reg         <= swmga_pkg::RST_WINDOW_LEN;
            thr_reg          <= swmga_pkg::RST_DOM_THRESH;
            gain_reg         <= swmga_pkg::RST_NOISE_GAIN;
            tight_reg        <= swmga_pkg::RST_FLAT_TIGHT;
            music_skip_reg   <= swmga_pkg::RST_MUSIC_SKIP;
            silence_skip_reg <= swmga_pkg::RST_SILENCE_SKIP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swmga_pkg::REG_ENABLE:       enable_reg       <= cfg_data[0];
                swmga_pkg::REG_WINDOW_LEN:   wlen_reg         <= cfg_data[swmga_pkg::WLEN_W-1:0];
                swmga_pkg::REG_DOM_THRESH:   thr_reg          <= cfg_data[swmga_pkg::THR_W-1:0];
                swmga_pkg::REG_NOISE_GAIN:   gain_reg         <= cfg_data;
                swmga_pkg::REG_FLAT_TIGHT:   tight_reg        <= cfg_data;
                swmga_pkg::REG_MUSIC_SKIP:   music_skip_reg   <= cfg_data[0];
                swmga_pkg::REG_SILENCE_SKIP: silence_skip_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // label ring: one write port, one registered read at the oldest slot
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            ring[wr_ptr_reg] <= lbl_reg;
        end
        rd_lbl_reg <= ring[oldest_reg];
    end

    // window pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else if (ctl.push)
        begin
            wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            occ_reg    <= occ_reg + OCC_W'(1);
        end
        else if (ctl.drop && (occ_reg != '0))
        begin
            oldest_reg <= ptr_inc(oldest_reg);
            occ_reg    <= occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swmga_pkg::NUM_LABELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < swmga_pkg::NUM_LABELS; i++)
            begin
                if (ctl.push && (lbl_reg == L_W'(i)))
                begin
                    cnt_reg[i] <= cnt_reg[i] + OCC_W'(1);
                end
                else if (ctl.drop && (occ_reg != '0) && (rd_lbl_reg == L_W'(i))
                         && (cnt_reg[i] != '0))
                begin
                    cnt_reg[i] <= cnt_reg[i] - OCC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_req_reg <= 1'b0;
        end
        else if (ctl.load_in)
        begin
            push_req_reg <= (cmd == swmga_pkg::CMD_PUSH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            lbl_reg        <= lbl_clean;
            query_reg      <= query_scene;
            rms_min_reg    <= base_rms_min;
            rms_border_reg <= base_rms_border;
            flat_max_reg   <= base_flat_max;
            flat_warn_reg  <= base_flat_warn;
        end
    end

    // most frequent label, ties to the lower code
    always_comb
    begin
        srch_lbl = swmga_pkg::LBL_UNKNOWN;
        srch_n   = '0;
        for (int i = 0; i < swmga_pkg::NUM_LABELS; i++)
        begin
            if (cnt_reg[i] > srch_n)
            begin
                srch_n   = cnt_reg[i];
                srch_lbl = L_W'(i);
            end
        end
    end

    assign qual_lhs = QW'({best_n_reg, 8'h00});
    assign qual_rhs = QW'(thr_reg) * QW'(occ_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.best)
        begin
            best_lbl_reg  <= srch_lbl;
            best_n_reg    <= srch_n;
            rms_prod_reg  <= rms_min_reg * gain_reg;
            warn_prod_reg <= tight_reg * swmga_pkg::Q16_085;
        end
        if (ctl.qual)
        begin
            if ((occ_reg != '0) && (qual_lhs >= qual_rhs))
            begin
                dom_reg <= best_lbl_reg;
            end
            else
            begin
                dom_reg <= swmga_pkg::LBL_UNKNOWN;
            end
            // Q4.12 gain: drop 12 fraction bits, saturate at full scale
            if (rms_prod_reg[2*Q_W-1:Q_W+12] != '0)
            begin
                rms_sat_reg <= '1;
            end
            else
            begin
                rms_sat_reg <= rms_prod_reg[Q_W+11:12];
            end
        end
    end

    assign border_prod = rms_sat_reg * swmga_pkg::Q16_033;
    assign adapt       = enable_reg && (occ_reg != '0) && (dom_reg == swmga_pkg::LBL_NOISE);
    assign tighten     = adapt && (tight_reg < flat_max_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            dominant_reg       <= dom_reg;
            out_rms_min_reg    <= adapt ? rms_sat_reg : rms_min_reg;
            out_rms_border_reg <= adapt ? border_prod[2*Q_W-1:Q_W] : rms_border_reg;
            out_flat_max_reg   <= tighten ? tight_reg : flat_max_reg;
            out_flat_warn_reg  <= tighten ? warn_prod_reg[2*Q_W-1:Q_W] : flat_warn_reg;
            skip_reg           <= enable_reg
                                  && ((music_skip_reg && (query_reg == swmga_pkg::LBL_MUSIC))
                                  || (silence_skip_reg && (query_reg == swmga_pkg::LBL_SILENCE)));
            fill_reg           <= swmga_pkg::FILL_W'(occ_reg);
        end
    end

    assign dominant       = dominant_reg;
    assign out_rms_min    = out_rms_min_reg;
    assign out_rms_border = out_rms_border_reg;
    assign out_flat_max   = out_flat_max_reg;
    assign out_flat_warn  = out_flat_warn_reg;
    assign asr_bypass     = skip_reg;
    assign fill           = fill_reg;

endmodule

### hdl/swmga_ctrl.sv
// Controller of the scene window majority gate adapter: sequences push, drop,
// evaluation and output load, and owns the input stall and output valid.
// Depends on swmga_pkg.
module swmga_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  swmga_pkg::dp_sts_t  sts,
    output swmga_pkg::ctl_cmd_t ctl
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_START     = 10'b00_0000_0010,
        S_PRE_RD    = 10'b00_0000_0100,
        S_PRE_DROP  = 10'b00_0000_1000,
        S_CHK       = 10'b00_0001_0000,
        S_TRIM_RD   = 10'b00_0010_0000,
        S_TRIM_DROP = 10'b00_0100_0000,
        S_BEST      = 10'b00_1000_0000,
        S_QUAL      = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (!sts.push_req)
                begin
                    state_next = S_BEST;
                end
                else if (sts.full)
                begin
                    state_next = S_PRE_RD;
                end
                else
                begin
                    ctl.push   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_PRE_RD:
            begin
                state_next = S_PRE_DROP;
            end
            S_PRE_DROP:
            begin
                ctl.drop   = 1'b1;
                state_next = S_START;
            end
            S_CHK:
            begin
                state_next = sts.over_limit ? S_TRIM_RD : S_BEST;
            end
            S_TRIM_RD:
            begin
                state_next = S_TRIM_DROP;
            end
            S_TRIM_DROP:
            begin
                ctl.drop   = 1'b1;
                state_next = S_CHK;
            end
            S_BEST:
            begin
                ctl.best   = 1'b1;
                state_next = S_QUAL;
            end
            S_QUAL:
            begin
                ctl.qual   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hdl/scene_window_majority_gate_adapter.sv
// Scene window majority gate adapter, top level. Depends on swmga_pkg, swmga_ctrl, swmga_dp.
// An evaluate-only item walks start, best, qualify and output load. A push adds the check
// state, each trim drop adds a read and a drop state, and a push into a full ring first
// passes the pre-read and pre-drop states. The sequencer takes no new beat until the last
// one's output load, and the single ring read port allows one drop per read.
// Reset: rst_n empties the window, clears the counters and reloads the config defaults.
module scene_window_majority_gate_adapter #(
    parameter int MAX_WINDOW = swmga_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swmga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swmga_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [swmga_pkg::LBL_W-1:0]         scene_label,
    input  logic [swmga_pkg::LBL_W-1:0]         query_scene,
    input  logic [swmga_pkg::Q16_W-1:0]         base_rms_min,
    input  logic [swmga_pkg::Q16_W-1:0]         base_rms_border,
    input  logic [swmga_pkg::Q16_W-1:0]         base_flat_max,
    input  logic [swmga_pkg::Q16_W-1:0]         base_flat_warn,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [swmga_pkg::LBL_W-1:0]         dominant,
    output logic [swmga_pkg::Q16_W-1:0]         out_rms_min,
    output logic [swmga_pkg::Q16_W-1:0]         out_rms_border,
    output logic [swmga_pkg::Q16_W-1:0]         out_flat_max,
    output logic [swmga_pkg::Q16_W-1:0]         out_flat_warn,
    output logic                                asr_bypass,
    output logic [swmga_pkg::FILL_W-1:0]        fill
);

    swmga_pkg::ctl_cmd_t ctl;
    swmga_pkg::dp_sts_t  sts;

    // Config writes land directly in the config registers, so never hold off a config beat.
    assign cfg_ready = 1'b1;

    // Controller: walks push, pre-drop and trim drops, then the three evaluate steps
    // (search, qualify, load). Hold the next input beat until the output load is done;
    // the output register lets the next beat enter while a result still waits.
    swmga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Datapath: ring of labels with one write and one registered read per cycle,
    // one counter per label, majority search and threshold multiplies, each
    // multiply registered before the next.
    swmga_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .scene_label     (scene_label),
        .query_scene     (query_scene),
        .base_rms_min    (base_rms_min),
        .base_rms_border (base_rms_border),
        .base_flat_max   (base_flat_max),
        .base_flat_warn  (base_flat_warn),
        .ctl             (ctl),
        .sts             (sts),
        .dominant        (dominant),
        .out_rms_min     (out_rms_min),
        .out_rms_border  (out_rms_border),
        .out_flat_max    (out_flat_max),
        .out_flat_warn   (out_flat_warn),
        .asr_bypass      (asr_bypass),
        .fill            (fill)
    );

endmodule

### hdl/swmga_chk.sv
// Port-level checker for the scene window majority gate adapter, with its bind.
// Depends on swmga_pkg and the top level's port list.
module swmga_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [swmga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [swmga_pkg::CFG_DATA_W-1:0]    cfg_data,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                cmd,
    input logic [swmga_pkg::LBL_W-1:0]         scene_label,
    input logic [swmga_pkg::LBL_W-1:0]         query_scene,
    input logic [swmga_pkg::Q16_W-1:0]         base_rms_min,
    input logic [swmga_pkg::Q16_W-1:0]         base_rms_border,
    input logic [swmga_pkg::Q16_W-1:0]         base_flat_max,
    input logic [swmga_pkg::Q16_W-1:0]         base_flat_warn,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [swmga_pkg::LBL_W-1:0]         dominant,
    input logic [swmga_pkg::Q16_W-1:0]         out_rms_min,
    input logic [swmga_pkg::Q16_W-1:0]         out_rms_border,
    input logic [swmga_pkg::Q16_W-1:0]         out_flat_max,
    input logic [swmga_pkg::Q16_W-1:0]         out_flat_warn,
    input logic                                asr_bypass,
    input logic [swmga_pkg::FILL_W-1:0]        fill
);

    // One item in flight: an accepted beat holds off the next one.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item still in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dominant) && $stable(fill)
                                      && $stable(out_rms_min) && $stable(asr_bypass)))
        else $error("stalled result changed");

    // Only real labels or unknown are reported.
    a_dom_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dominant <= swmga_pkg::LBL_UNKNOWN))
        else $error("dominant label out of range");

    // An empty window reports unknown.
    a_empty_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (fill == '0)) |-> (dominant == swmga_pkg::LBL_UNKNOWN))
        else $error("empty window reported a dominant label");

endmodule

bind scene_window_majority_gate_adapter swmga_chk u_swmga_chk (.*);

### tb/sv/swmga_checker.sv
// Scoreboard for the scene window majority gate adapter: follows register writes,
// predicts one result per accepted input beat and compares result beats in order.
// Depends on swmga_pkg.
module swmga_checker
    import swmga_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  cmd,
    input  logic [LBL_W-1:0]      scene_label,
    input  logic [LBL_W-1:0]      query_scene,
    input  logic [Q16_W-1:0]      base_rms_min,
    input  logic [Q16_W-1:0]      base_rms_border,
    input  logic [Q16_W-1:0]      base_flat_max,
    input  logic [Q16_W-1:0]      base_flat_warn,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [LBL_W-1:0]      dominant,
    input  logic [Q16_W-1:0]      out_rms_min,
    input  logic [Q16_W-1:0]      out_rms_border,
    input  logic [Q16_W-1:0]      out_flat_max,
    input  logic [Q16_W-1:0]      out_flat_warn,
    input  logic                  asr_bypass,
    input  logic [FILL_W-1:0]     fill,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    adapted
);

    typedef struct packed {
        logic [LBL_W-1:0]  dominant;
        logic [Q16_W-1:0]  rms_min;
        logic [Q16_W-1:0]  rms_border;
        logic [Q16_W-1:0]  flat_max;
        logic [Q16_W-1:0]  flat_warn;
        logic              skip;
        logic [FILL_W-1:0] fill;
    } gate_result_t;

    // register copies
    logic              en_r;
    logic [WLEN_W-1:0] wlen_r;
    logic [THR_W-1:0]  thr_r;
    logic [Q16_W-1:0]  gain_r;
    logic [Q16_W-1:0]  tight_r;
    logic              music_r;
    logic              silence_r;

    // label window
    logic [LBL_W-1:0]  scene_hist [MAX_WINDOW_DEF];
    int                hist_head;
    int                hist_fill;
    int                label_tally [NUM_LABELS];

    gate_result_t      gate_expect_q [$];

    function automatic void drop_oldest_label();
        logic [LBL_W-1:0] lbl;
        if (hist_fill == 0)
            return;
        lbl = scene_hist[hist_head];
        if (lbl < NUM_LABELS && label_tally[lbl] > 0)
            label_tally[lbl]--;
        hist_head = (hist_head + 1) % MAX_WINDOW_DEF;
        hist_fill--;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gate_result_t     exp_r;
        gate_result_t     got_r;
        int               cap;
        int               slot;
        int               best_n;
        logic [LBL_W-1:0] code;
        logic [LBL_W-1:0] best;
        logic [31:0]      wide;
        if (!rst_n)
        begin
            en_r      = RST_ENABLE;
            wlen_r    = RST_WINDOW_LEN;
            thr_r     = RST_DOM_THRESH;
            gain_r    = RST_NOISE_GAIN;
            tight_r   = RST_FLAT_TIGHT;
            music_r   = RST_MUSIC_SKIP;
            silence_r = RST_SILENCE_SKIP;
            foreach (scene_hist[i])
                scene_hist[i] = '0;
            foreach (label_tally[i])
                label_tally[i] = 0;
            hist_head = 0;
            hist_fill = 0;
            gate_expect_q.delete();
            errors  = 0;
            pending = 0;
            checked = 0;
            adapted = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ENABLE:       en_r      = cfg_data[0];
                    REG_WINDOW_LEN:   wlen_r    = cfg_data[WLEN_W-1:0];
                    REG_DOM_THRESH:   thr_r     = cfg_data[THR_W-1:0];
                    REG_NOISE_GAIN:   gain_r    = cfg_data;
                    REG_FLAT_TIGHT:   tight_r   = cfg_data;
                    REG_MUSIC_SKIP:   music_r   = cfg_data[0];
                    REG_SILENCE_SKIP: silence_r = cfg_data[0];
                    default: ;
                endcase
            end

            // result side first: a result never belongs to the beat taken at the same edge
            if (out_valid && !out_stall)
            begin
                got_r = '{dominant, out_rms_min, out_rms_border, out_flat_max,
                          out_flat_warn, asr_bypass, fill};
                if (gate_expect_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result beat with nothing expected: dom %0d fill %0d",
                                 $time, got_r.dominant, got_r.fill);
                end
                else
                begin
                    exp_r = gate_expect_q[0];
                    gate_expect_q.delete(0);
                    checked++;
                    if (got_r.dominant !== exp_r.dominant ||
                        got_r.rms_min !== exp_r.rms_min ||
                        got_r.rms_border !== exp_r.rms_border ||
                        got_r.flat_max !== exp_r.flat_max ||
                        got_r.flat_warn !== exp_r.flat_warn ||
                        got_r.skip !== exp_r.skip ||
                        got_r.fill !== exp_r.fill)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch on result %0d\n",
                                      "  expected dom %0d rms %0d/%0d flat %0d/%0d skip %0d fill %0d\n",
                                      "  actual   dom %0d rms %0d/%0d flat %0d/%0d skip %0d fill %0d"},
                                     $time, checked,
                                     exp_r.dominant, exp_r.rms_min, exp_r.rms_border,
                                     exp_r.flat_max, exp_r.flat_warn, exp_r.skip, exp_r.fill,
                                     got_r.dominant, got_r.rms_min, got_r.rms_border,
                                     got_r.flat_max, got_r.flat_warn, got_r.skip, got_r.fill);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_PUSH)
                begin
                    code = (scene_label >= NUM_LABELS) ? LBL_UNKNOWN : scene_label;
                    cap  = (wlen_r > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(wlen_r);
                    if (hist_fill >= MAX_WINDOW_DEF)
                        drop_oldest_label();
                    slot = (hist_head + hist_fill) % MAX_WINDOW_DEF;
                    scene_hist[slot] = code;
                    label_tally[code]++;
                    hist_fill++;
                    while (hist_fill > cap)
                        drop_oldest_label();
                end

                // most frequent label, lower code wins a tie
                best   = LBL_UNKNOWN;
                best_n = 0;
                if (hist_fill != 0)
                begin
                    for (int i = 0; i < NUM_LABELS; i++)
                    begin
                        if (label_tally[i] > best_n)
                        begin
                            best_n = label_tally[i];
                            best   = LBL_W'(i);
                        end
                    end
                    if (best_n * 256 < int'(thr_r) * hist_fill)
                        best = LBL_UNKNOWN;
                end

                exp_r.dominant   = best;
                exp_r.rms_min    = base_rms_min;
                exp_r.rms_border = base_rms_border;
                exp_r.flat_max   = base_flat_max;
                exp_r.flat_warn  = base_flat_warn;
                exp_r.fill       = FILL_W'(hist_fill);
                exp_r.skip       = en_r && ((music_r && query_scene == LBL_MUSIC) ||
                                            (silence_r && query_scene == LBL_SILENCE));

                if (en_r && hist_fill != 0 && best == LBL_NOISE)
                begin
                    adapted++;
                    wide = ({16'd0, base_rms_min} * {16'd0, gain_r}) >> 12;
                    exp_r.rms_min = (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
                    wide = ({16'd0, exp_r.rms_min} * {16'd0, Q16_033}) >> 16;
                    exp_r.rms_border = wide[15:0];
                    if (tight_r < base_flat_max)
                    begin
                        exp_r.flat_max = tight_r;
                        wide = ({16'd0, tight_r} * {16'd0, Q16_085}) >> 16;
                        exp_r.flat_warn = wide[15:0];
                    end
                end
                gate_expect_q.insert(gate_expect_q.size(), exp_r);
            end
            pending = gate_expect_q.size();
        end
    end

endmodule

### tb/sv/scene_window_majority_gate_adapter_tb.sv
// Testbench top for the scene window majority gate adapter: clock, reset, stimulus and verdict.
// Depends on swmga_pkg, the adapter RTL and swmga_checker, which predicts and compares.
module scene_window_majority_gate_adapter_tb;
    import swmga_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // well above the slowest correct run
    localparam int SETTLE      = 16;       // hold-off after every expected result is back
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 163;      // about 1300 random beats over all phases
    // index past the last register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n           = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  in_valid        = 1'b0;
    logic                  in_stall;
    logic                  cmd             = CMD_EVAL;
    logic [LBL_W-1:0]      scene_label     = '0;
    logic [LBL_W-1:0]      query_scene     = '0;
    logic [Q16_W-1:0]      base_rms_min    = '0;
    logic [Q16_W-1:0]      base_rms_border = '0;
    logic [Q16_W-1:0]      base_flat_max   = '0;
    logic [Q16_W-1:0]      base_flat_warn  = '0;
    logic                  out_valid;
    logic                  out_stall       = 1'b0;
    logic [LBL_W-1:0]      dominant;
    logic [Q16_W-1:0]      out_rms_min;
    logic [Q16_W-1:0]      out_rms_border;
    logic [Q16_W-1:0]      out_flat_max;
    logic [Q16_W-1:0]      out_flat_warn;
    logic                  asr_bypass;
    logic [FILL_W-1:0]     fill;

    int   errors;
    int   pending;
    int   checked;
    int   adapted;
    int   cycles      = 0;
    int   items_sent  = 0;
    int   pushes_sent = 0;
    int   settings    = 0;
    logic calm        = 1'b0;   // high: neither side idles

    scene_window_majority_gate_adapter uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .scene_label     (scene_label),
        .query_scene     (query_scene),
        .base_rms_min    (base_rms_min),
        .base_rms_border (base_rms_border),
        .base_flat_max   (base_flat_max),
        .base_flat_warn  (base_flat_warn),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dominant        (dominant),
        .out_rms_min     (out_rms_min),
        .out_rms_border  (out_rms_border),
        .out_flat_max    (out_flat_max),
        .out_flat_warn   (out_flat_warn),
        .asr_bypass      (asr_bypass),
        .fill            (fill)
    );

    swmga_checker u_score (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .scene_label     (scene_label),
        .query_scene     (query_scene),
        .base_rms_min    (base_rms_min),
        .base_rms_border (base_rms_border),
        .base_flat_max   (base_flat_max),
        .base_flat_warn  (base_flat_warn),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .dominant        (dominant),
        .out_rms_min     (out_rms_min),
        .out_rms_border  (out_rms_border),
        .out_flat_max    (out_flat_max),
        .out_flat_warn   (out_flat_warn),
        .asr_bypass      (asr_bypass),
        .fill            (fill),
        .errors          (errors),
        .pending         (pending),
        .checked         (checked),
        .adapted         (adapted)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run once the total cycle count passes the limit, as when the handshakes stop moving.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: stall at random with a chance of about 30 percent, never while calm.
    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

    // Base threshold value with the extremes weighted up.
    function automatic logic [Q16_W-1:0] pick_q16();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return Q16_W'($urandom);
        endcase
    endfunction

    // Send one input beat; optionally idle first. Valid stays high when beats run
    // back to back, so it is never lowered and raised in the same step.
    task automatic send_item(input logic c, input logic [LBL_W-1:0] lbl,
                             input logic [LBL_W-1:0] q,
                             input logic [Q16_W-1:0] rmin, input logic [Q16_W-1:0] rbord,
                             input logic [Q16_W-1:0] fmax, input logic [Q16_W-1:0] fwarn);
        if (!calm && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        scene_label     <= lbl;
        query_scene     <= q;
        base_rms_min    <= rmin;
        base_rms_border <= rbord;
        base_flat_max   <= fmax;
        base_flat_warn  <= fwarn;
        // hold the beat until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
        if (c == CMD_PUSH)
            pushes_sent++;
    endtask

    // Stop sending and wait until every expected result has come, then settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Drain the block, then write every register plus the unused index.
    task automatic apply_setting(input logic [15:0] en, input logic [15:0] wlen,
                                 input logic [15:0] thr, input logic [15:0] gain,
                                 input logic [15:0] tight, input logic [15:0] mus,
                                 input logic [15:0] sil);
        drain();
        write_reg(REG_ENABLE, en);
        write_reg(REG_WINDOW_LEN, wlen);
        write_reg(REG_DOM_THRESH, thr);
        write_reg(REG_NOISE_GAIN, gain);
        write_reg(REG_FLAT_TIGHT, tight);
        write_reg(REG_MUSIC_SKIP, mus);
        write_reg(REG_SILENCE_SKIP, sil);
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial
    begin
        logic [LBL_W-1:0] favorite;
        logic [LBL_W-1:0] lbl;
        logic             c;

        // Hold reset from time zero, release it on a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, reset register values ----
        // Evaluate the empty window: unknown, no adaptation, silence query skips.
        send_item(CMD_EVAL, LBL_SILENCE, LBL_SILENCE, 16'd1234, 16'd5678, 16'd40000, 16'd30000);
        // Noise with all-ones base: rms floor saturates, flatness tightens.
        send_item(CMD_PUSH, LBL_NOISE, LBL_MUSIC, '1, '1, '1, '1);
        // Noise with zero base: flat max of zero is never tightened.
        send_item(CMD_PUSH, LBL_NOISE, LBL_NOISE, '0, '0, '0, '0);
        // Out-of-range codes are stored as unknown; query codes 6 and 7 match nothing.
        send_item(CMD_PUSH, 3'd6, 3'd6, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, 3'd7, 3'd7, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, LBL_SILENCE, 3'd3, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, LBL_MUSIC, 3'd4, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, 3'd3, LBL_UNKNOWN, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, 3'd4, LBL_SILENCE, '1, '1, '1, '1);
        // Window now full at eight labels; this push drops the oldest.
        send_item(CMD_PUSH, LBL_NOISE, LBL_MUSIC, 16'd30000, 16'd9000, 16'd50000, 16'd40000);

        // Shrink the window: evaluate still sees the old fill, the next push trims.
        apply_setting(1, 2, 154, 8192, 45875, 1, 1);
        send_item(CMD_EVAL, LBL_SILENCE, LBL_MUSIC, pick_q16(), pick_q16(), pick_q16(), pick_q16());
        send_item(CMD_PUSH, LBL_NOISE, LBL_SILENCE, '1, '1, '1, '1);
        send_item(CMD_EVAL, LBL_SILENCE, LBL_NOISE, '1, '1, '1, '1);

        // Zero window length: a push leaves the window empty.
        apply_setting(1, 0, 154, 8192, 45875, 1, 1);
        send_item(CMD_PUSH, LBL_NOISE, LBL_MUSIC, '1, '1, '1, '1);
        send_item(CMD_EVAL, LBL_NOISE, LBL_SILENCE, '1, '1, '1, '1);

        // Threshold above 256: an all-noise window still reports unknown.
        apply_setting(1, 8, 300, 8192, 45875, 1, 1);
        send_item(CMD_PUSH, LBL_NOISE, LBL_MUSIC, '1, '1, '1, '1);
        send_item(CMD_PUSH, LBL_NOISE, LBL_MUSIC, '1, '1, '1, '1);

        // ---- random part, one register setting per phase ----
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_setting(RST_ENABLE, RST_WINDOW_LEN, RST_DOM_THRESH, RST_NOISE_GAIN,
                                 RST_FLAT_TIGHT, RST_MUSIC_SKIP, RST_SILENCE_SKIP);
                // full capacity, any majority qualifies, largest gain
                1: apply_setting(1, 64, 0, 16'hFFFF, 16'hFFFF, 0, 1);
                // disabled, unanimity required, zero gain and tight limit
                2: apply_setting(0, 1, 256, 0, 0, 1, 0);
                // length past capacity keeps the ring full; no label can qualify
                3: apply_setting(1, 127, 511, 4096, 0, 1, 1);
                4: apply_setting(1, 5, 128, 16'($urandom), 16'($urandom), 0, 0);
                5: apply_setting(1, 0, 154, 8192, 45875, 1, 1);
                // raw data words: only the low bits of each register count
                6: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom));
                default: apply_setting(1, 3, 200, 12288, 32768, 1, 1);
            endcase

            favorite = LBL_NOISE;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // One long stretch early in the full-window phase runs without idling.
                calm = (p == 1 && n < 120);
                // Steer the window toward one label for a while so that majorities form.
                if (n % 24 == 0)
                    favorite = $urandom_range(1) ? LBL_NOISE : LBL_W'($urandom_range(7));
                lbl = ($urandom_range(99) < 60) ? favorite : LBL_W'($urandom_range(7));
                c   = ($urandom_range(99) < 75) ? CMD_PUSH : CMD_EVAL;
                send_item(c, lbl, LBL_W'($urandom_range(7)),
                          pick_q16(), pick_q16(), pick_q16(), pick_q16());
                // now and then hold off until every result is back
                if ($urandom_range(199) == 0)
                    drain();
            end
        end
        calm = 1'b0;

        // Let the last results come out, then settle.
        drain();

        $display("Covered %0d input beats (%0d label pushes) across %0d register settings;",
                 items_sent, pushes_sent, settings + 1);
        $display("checked %0d results, %0d of them with noise adaptation applied.",
                 checked, adapted);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
hdl/swmga_pkg.sv
hdl/swmga_dp.sv
hdl/swmga_ctrl.sv
hdl/scene_window_majority_gate_adapter.sv
hdl/swmga_chk.sv
tb/sv/swmga_checker.sv
tb/sv/scene_window_majority_gate_adapter_tb.sv
